>>> hdl/peer_id_table_unit_macros.svh
// Assertion macros used by the peer identifier table RTL.
`ifndef PEER_ID_TABLE_UNIT_MACROS_SVH
`define PEER_ID_TABLE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define PIT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PIT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PIT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/pit_pkg.sv
// Types and constants of the peer identifier table.
`timescale 1ns / 1ps
package pit_pkg;

  localparam int ID_W      = 64;
  localparam int WORD_W    = 32;
  localparam int CNT_OUT_W = 5;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_FIND   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_DUP      = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ID_W-1:0]   peer_id;
    logic [WORD_W-1:0] peer_info;
  } pit_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [WORD_W-1:0]    found_info;
    logic [CNT_OUT_W-1:0] entry_count;
  } pit_rsp_t;

  typedef struct packed {
    logic pend;
    logic hit;
  } pit_cmp_t;

endpackage

>>> hdl/peer_id_table_unit.sv
// Peer identifier table: add, remove and find over a packed table held in a RAM.
// Flow: an add to a full table or an unused kind goes from idle straight to the reply state.
// Otherwise the entries are read in order through the RAM and comparator until a hit or the end.
// A hit on a remove moves each later entry down one slot before the reply.
// A new transfer is taken once the reply is registered.
// Reset clears the entry count and the control state; table contents are not cleared.
`timescale 1ns / 1ps
`include "peer_id_table_unit_macros.svh"
module peer_id_table_unit #(
  parameter int TABLE_DEPTH = 16,
  parameter int INFO_WIDTH  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pit_pkg::pit_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pit_pkg::pit_rsp_t out_data
);
  import pit_pkg::*;

  localparam int IW = (INFO_WIDTH < WORD_W) ? INFO_WIDTH : WORD_W;
  localparam int EW = ID_W + IW;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_RESP} state_t;

  state_t        state_r, state_nxt;
  pit_req_t      req_r, req_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          wpend_r, wpend_nxt;
  logic [AW-1:0] widx_r, widx_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [IW-1:0] found_r, found_nxt;
  logic          out_valid_r, out_valid_nxt;
  pit_rsp_t      out_data_r, out_data_nxt;

  logic          issue;
  logic          scan_miss;
  pit_cmp_t      cmp;
  logic [CW-1:0] hit_idx;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [EW-1:0] rdata;

  assign issue     = (state_r == S_SCAN) && (rd_idx_r < count_r) && !cmp.hit;
  assign scan_miss = (state_r == S_SCAN) && !cmp.pend && (rd_idx_r == count_r);

  pit_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (rdata)
  );

  pit_cmp #(.CW(CW)) u_cmp (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .issue_idx (rd_idx_r),
    .key       (req_r.peer_id),
    .rd_id     (rdata[EW-1:IW]),
    .cmp       (cmp),
    .hit_idx   (hit_idx)
  );

  always_comb begin
    we    = 1'b0;
    waddr = count_r[AW-1:0];
    wdata = {req_r.peer_id, req_r.peer_info[IW-1:0]};
    if (state_r == S_SHIFT) begin
      we    = wpend_r;
      waddr = widx_r;
      wdata = rdata;
    end else if (scan_miss && (req_r.kind == KIND_ADD)) begin
      we = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    wpend_nxt     = 1'b0;
    widx_nxt      = widx_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data;
          rd_idx_nxt = '0;
          status_nxt = ST_OK;
          found_nxt  = '0;
          if ((in_data.kind == KIND_ADD) && (count_r == DepthC)) begin
            status_nxt = ST_FULL;
            state_nxt  = S_RESP;
          end else if (in_data.kind inside {KIND_ADD, KIND_REMOVE, KIND_FIND}) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (cmp.hit) begin
          case (req_r.kind)
            KIND_ADD: begin
              status_nxt = ST_DUP;
              state_nxt  = S_RESP;
            end
            KIND_REMOVE: begin
              rd_idx_nxt = hit_idx + 1'b1;
              state_nxt  = S_SHIFT;
            end
            default: begin
              found_nxt = rdata[IW-1:0];
              state_nxt = S_RESP;
            end
          endcase
        end else if (scan_miss) begin
          if (req_r.kind == KIND_ADD) begin
            count_nxt = count_r + 1'b1;
          end else begin
            status_nxt = ST_NOTFOUND;
          end
          state_nxt = S_RESP;
        end
      end
      S_SHIFT: begin
        if (rd_idx_r < count_r) begin
          wpend_nxt  = 1'b1;
          widx_nxt   = rd_idx_r[AW-1:0] - 1'b1;
          rd_idx_nxt = rd_idx_r + 1'b1;
        end else if (!wpend_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.found_info  = WORD_W'(found_r);
          out_data_nxt.entry_count = CNT_OUT_W'(count_r);
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wpend_r     <= wpend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    rd_idx_r   <= rd_idx_nxt;
    widx_r     <= widx_nxt;
    status_r   <= status_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PIT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `PIT_ASSERT_NOW(a_count_step, clk, rst_n, $past(rst_n), (count_r + 1'b1 - $past(count_r)) <= CW'(2))
  `PIT_ASSERT_NOW(a_count_bound, clk, rst_n, out_valid_r && (out_data_r.status == ST_FULL), out_data_r.entry_count == CNT_OUT_W'(TABLE_DEPTH))

endmodule

>>> hdl/pit_ram.sv
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps
module pit_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/pit_cmp.sv
// Identifier comparator that tracks which slot the read data belongs to.
`timescale 1ns / 1ps
module pit_cmp #(
  parameter int CW = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  issue,
  input  logic [CW-1:0]         issue_idx,
  input  logic [pit_pkg::ID_W-1:0] key,
  input  logic [pit_pkg::ID_W-1:0] rd_id,
  output pit_pkg::pit_cmp_t     cmp,
  output logic [CW-1:0]         hit_idx
);
  import pit_pkg::*;

  logic          pend_r;
  logic [CW-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= issue;
    end
    idx_r <= issue_idx;
  end

  assign cmp.pend = pend_r;
  assign cmp.hit  = pend_r && (rd_id == key);
  assign hit_idx  = idx_r;

endmodule
